FILE: sv/swtq_pkg.sv
// Shared types, codes and helpers for the sorted wakeup timer queue.
`default_nettype none

package swtq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TICK_W      = 63;
   localparam int DUR_W       = 32;
   localparam int PRIO_W      = 6;
   localparam int THREAD_W    = 8;
   localparam int KIND_W      = 3;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_SLEEP = 1'b1;

   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_WOKEN    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INSERT,
      ST_POP
   } state_type;

   typedef struct packed {
      logic [TICK_W-1:0]   wake;
      logic [PRIO_W-1:0]   prio;
      logic [THREAD_W-1:0] thread;
   } entry_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic              insert;
      logic              pop;
      entry_type         new_entry;
      logic [TICK_W-1:0] tick;
   } cmd_type;

   // true when a new entry (wake, prio) sorts ahead of stored entry e
   function automatic logic goes_before(input logic [TICK_W-1:0] wake,
                                        input logic [PRIO_W-1:0] prio,
                                        input entry_type e);
      logic res;
      if (wake != e.wake) res = (wake < e.wake);
      else                res = (prio > e.prio);
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: sv/sorted_wakeup_timer_queue.sv
// Top level: controller, tick counter and chain of queue cells.
//
//  channel  ports                                   direction  beat taken when
//  -------  --------------------------------------  ---------  -------------------------
//  request  start, busy, req_operation,             in         start && !busy
//           req_sleep_ticks, req_priority_req,
//           req_thread_id
//  result   rsp_valid, rsp_kind, rsp_woken_thread,  out        every cycle rsp_valid is high
//           rsp_tick_now, rsp_last
//
// Steps: a sleep request that is ignored or rejected gives its beat from the EXEC
// state through the result register; an accepted one passes EXEC (wake tick add), then
// INSERT (one insert step in every cell at once). A tick passes EXEC (counter step),
// then the first POP step, and gives one more beat per cycle for each further due entry:
// one pop step of the cell chain per beat.
// busy drops in the cycle the final beat (rsp_last) is shown.
// Reset clears the counter, the fill count and the controller; cell contents are
// left as they are and only slots below the fill count are ever read.
// The receiver cannot stall: every rsp_valid beat is taken in its cycle.
`default_nettype none

module sorted_wakeup_timer_queue #(
   parameter int QUEUE_DEPTH = swtq_pkg::QUEUE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_operation,
   input  wire logic signed [swtq_pkg::DUR_W-1:0] req_sleep_ticks,
   input  wire logic [swtq_pkg::PRIO_W-1:0]    req_priority_req,
   input  wire logic [swtq_pkg::THREAD_W-1:0]  req_thread_id,
   output logic                                rsp_valid,
   output logic [swtq_pkg::KIND_W-1:0]         rsp_kind,
   output logic [swtq_pkg::THREAD_W-1:0]       rsp_woken_thread,
   output logic [swtq_pkg::TICK_W-1:0]         rsp_tick_now,
   output logic                                rsp_last
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // controller state
   swtq_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [swtq_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [swtq_pkg::TICK_W-1:0] wake_ff, wake_in;

   // latched request beat
   logic                          op_ff, op_in;
   logic [swtq_pkg::DUR_W-1:0]    dur_ff, dur_in;
   logic [swtq_pkg::PRIO_W-1:0]   prio_ff, prio_in;
   logic [swtq_pkg::THREAD_W-1:0] thr_ff, thr_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swtq_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [swtq_pkg::THREAD_W-1:0] rsp_thr_ff, rsp_thr_in;
   logic [swtq_pkg::TICK_W-1:0]   rsp_tick_ff, rsp_tick_in;
   logic                          rsp_last_ff, rsp_last_in;

   swtq_pkg::cmd_type   cmd;
   swtq_pkg::entry_type cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_before;
   logic [QUEUE_DEPTH-1:0] cell_due;
   logic [QUEUE_DEPTH-1:0] occ;

   logic                 accept;
   logic                 nonpositive;
   logic                 full;
   logic [swtq_pkg::TICK_W:0] wake_sum;

   assign accept      = start && !busy;
   assign busy        = (state_ff != swtq_pkg::ST_IDLE);
   assign nonpositive = (dur_ff == '0) || dur_ff[swtq_pkg::DUR_W-1];
   assign full        = (count_ff == CNT_W'(QUEUE_DEPTH));
   // duration is positive here, so it fits in 31 bits; saturate on carry out
   assign wake_sum    = {1'b0, tick_ff} +
                        (swtq_pkg::TICK_W+1)'(dur_ff[swtq_pkg::DUR_W-2:0]);

   // occupancy of each slot follows from the fill count
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         occ[i] = (CNT_W'(i) < count_ff);
      end
   end

   // ---------------- cell chain ----------------
   generate
      for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         swtq_pkg::entry_type prev_entry;
         swtq_pkg::entry_type next_entry;
         logic                prev_before;

         if (g == 0) begin : g_head
            assign prev_entry  = cmd.new_entry;
            assign prev_before = 1'b0;
         end else begin : g_mid
            assign prev_entry  = cell_entry[g-1];
            assign prev_before = cell_before[g-1];
         end

         if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign next_entry = cell_entry[g];
         end else begin : g_inner
            assign next_entry = cell_entry[g+1];
         end

         swtq_cell u_cell (
            .clock         (clock),
            .cmd_i         (cmd),
            .occ_i         (occ[g]),
            .prev_entry_i  (prev_entry),
            .prev_before_i (prev_before),
            .next_entry_i  (next_entry),
            .entry_o       (cell_entry[g]),
            .before_o      (cell_before[g]),
            .due_o         (cell_due[g])
         );
      end
   endgenerate

   // ---------------- controller ----------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      tick_in      = tick_ff;
      wake_in      = wake_ff;
      op_in        = op_ff;
      dur_in       = dur_ff;
      prio_in      = prio_ff;
      thr_in       = thr_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_thr_in   = rsp_thr_ff;
      rsp_tick_in  = rsp_tick_ff;
      rsp_last_in  = rsp_last_ff;

      cmd.insert           = 1'b0;
      cmd.pop              = 1'b0;
      cmd.new_entry.wake   = wake_ff;
      cmd.new_entry.prio   = prio_ff;
      cmd.new_entry.thread = thr_ff;
      cmd.tick             = tick_ff;

      unique case (state_ff)
         swtq_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               dur_in   = req_sleep_ticks;
               prio_in  = req_priority_req;
               thr_in   = req_thread_id;
               state_in = swtq_pkg::ST_EXEC;
            end
         end
         swtq_pkg::ST_EXEC: begin
            if (op_ff == swtq_pkg::OP_TICK) begin
               tick_in  = tick_ff + swtq_pkg::TICK_W'(1);   // wraps modulo 2^63
               state_in = swtq_pkg::ST_POP;
            end else if (nonpositive || full) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = nonpositive ? swtq_pkg::KIND_IGNORED : swtq_pkg::KIND_FULL;
               rsp_thr_in   = thr_ff;
               rsp_tick_in  = tick_ff;
               rsp_last_in  = 1'b1;
               state_in     = swtq_pkg::ST_IDLE;
            end else begin
               wake_in  = wake_sum[swtq_pkg::TICK_W] ? '1
                                                     : wake_sum[swtq_pkg::TICK_W-1:0];
               state_in = swtq_pkg::ST_INSERT;
            end
         end
         swtq_pkg::ST_INSERT: begin
            cmd.insert   = 1'b1;
            count_in     = count_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_kind_in  = swtq_pkg::KIND_ACCEPTED;
            rsp_thr_in   = thr_ff;
            rsp_tick_in  = tick_ff;
            rsp_last_in  = 1'b1;
            state_in     = swtq_pkg::ST_IDLE;
         end
         swtq_pkg::ST_POP: begin
            rsp_valid_in = 1'b1;
            rsp_tick_in  = tick_ff;
            if (occ[0] && cell_due[0]) begin
               // head is due: report it and shift the chain toward the head
               cmd.pop     = 1'b1;
               count_in    = count_ff - CNT_W'(1);
               rsp_kind_in = swtq_pkg::KIND_WOKEN;
               rsp_thr_in  = cell_entry[0].thread;
               rsp_last_in = !(occ[1] && cell_due[1]);
               if (rsp_last_in) state_in = swtq_pkg::ST_IDLE;
            end else begin
               // only reached on the first pop step: nothing due this tick
               rsp_kind_in = swtq_pkg::KIND_NONE;
               rsp_thr_in  = '0;
               rsp_last_in = 1'b1;
               state_in    = swtq_pkg::ST_IDLE;
            end
         end
         default: state_in = swtq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swtq_pkg::ST_IDLE;
         count_ff     <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wake_ff     <= wake_in;
      op_ff       <= op_in;
      dur_ff      <= dur_in;
      prio_ff     <= prio_in;
      thr_ff      <= thr_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_thr_ff  <= rsp_thr_in;
      rsp_tick_ff <= rsp_tick_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_woken_thread = rsp_thr_ff;
   assign rsp_tick_now     = rsp_tick_ff;
   assign rsp_last         = rsp_last_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count above queue depth");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !full)
      else $error("insert into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> count_ff != '0)
      else $error("pop from an empty queue");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> state_ff == swtq_pkg::ST_IDLE)
      else $error("controller busy after final beat");

   a_more_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> state_ff == swtq_pkg::ST_POP)
      else $error("non-final beat outside a pop run");

endmodule

`default_nettype wire

FILE: sv/swtq_cell.sv
// One slot of the sorted queue: holds an entry, shifts up on insert, down on pop.
`default_nettype none

module swtq_cell (
   input  wire logic              clock,
   input  wire swtq_pkg::cmd_type cmd_i,
   input  wire logic              occ_i,         // slot holds a live entry
   input  wire swtq_pkg::entry_type prev_entry_i, // neighbor toward head
   input  wire logic              prev_before_i,
   input  wire swtq_pkg::entry_type next_entry_i, // neighbor toward tail
   output swtq_pkg::entry_type    entry_o,
   output logic                   before_o,
   output logic                   due_o
);

   swtq_pkg::entry_type entry_ff;
   swtq_pkg::entry_type entry_in;

   // empty slots always accept the new entry or a shifted one
   assign before_o = !occ_i ||
                     swtq_pkg::goes_before(cmd_i.new_entry.wake, cmd_i.new_entry.prio,
                                           entry_ff);
   assign due_o    = (entry_ff.wake <= cmd_i.tick);
   assign entry_o  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd_i.insert && before_o) begin
         entry_in = prev_before_i ? prev_entry_i : cmd_i.new_entry;
      end else if (cmd_i.pop) begin
         entry_in = next_entry_i;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
